@@ rtl/core/kmg_pkg.sv @@
package kmg_pkg;

	localparam int MAX_CLIENTS    = 64;
	localparam int MAX_FACILITIES = 64;
	localparam int DIST_WIDTH     = 16;

	localparam int CW   = $clog2(MAX_CLIENTS);
	localparam int FW   = $clog2(MAX_FACILITIES);
	localparam int AW   = CW + FW;
	localparam int CNTW = 7;
	localparam int BDW  = DIST_WIDTH + 1;
	localparam int COSTW = 23;
	localparam int TOTW = 22;
	localparam int PAW  = 4;

	localparam logic [PAW-1:0] REG_CLIENTS    = 4'h0;
	localparam logic [PAW-1:0] REG_FACILITIES = 4'h4;
	localparam logic [PAW-1:0] REG_LIMIT      = 4'h8;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_START = 1'b1;

	typedef struct packed {
		logic [6:0] nc;
		logic [6:0] nf;
		logic [6:0] k;
	} kmg_cfg_t;

	typedef struct packed {
		logic              cmd;
		logic [5:0]        client_index;
		logic [5:0]        facility_index;
		logic [15:0]       distance;
	} kmg_req_t;

	typedef struct packed {
		logic [5:0]  client_id;
		logic [5:0]  assigned_facility;
		logic [15:0] client_distance;
		logic [21:0] cost_sum;
		logic [6:0]  opened_count;
		logic        last;
	} kmg_res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_EVAL,
		ST_DRAIN,
		ST_PICK,
		ST_UPD,
		ST_UPD_DRAIN,
		ST_ASSIGN,
		ST_ASSIGN_DRAIN,
		ST_FETCH,
		ST_EMIT
	} kmg_state_t;

	function automatic logic [6:0] clamp_cnt(input logic [6:0] v, input int hi);
		logic [6:0] r;
		r = v;
		if (v == '0) r = 7'd1;
		else if (int'(v) > hi) r = 7'(hi);
		return r;
	endfunction

endpackage

@@ rtl/core/kmg_if.sv @@
interface kmg_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/kmedian_greedy_open_unit.sv @@
// channel | dir | payload
// req     | in  | cmd, client_index, facility_index, distance
// res     | out | client_id, assigned_facility, client_distance, cost_sum, opened_count, last
// A load request writes one distance into the matrix RAM. A start request runs an init step,
// then rounds: each round scans every closed facility over all clients (open ones are skipped),
// picks the cheapest and updates each client's best distance; a round with no gain ends after its
// scan and the pick. Then come assignment, a fetch step and one emitted row per client, held by res.ready.
// Reset is asynchronous; the matrix RAM is not cleared.
// Result rows wait on res.ready; no request is taken until the last row leaves.
module kmedian_greedy_open_unit (
	input  logic                    clk,
	input  logic                    arst_n,
	kmg_if.sink                     req,
	kmg_if.source                   res,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [kmg_pkg::PAW-1:0] paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);
	import kmg_pkg::*;

	kmg_cfg_t cfg;
	kmg_req_t r;
	logic busy, acc, we;
	logic [AW-1:0] raddr;
	logic [DIST_WIDTH-1:0] rdata;

	assign r = req.data;
	assign req.ready = !busy;
	assign acc = req.valid && req.ready;
	assign we = acc && (r.cmd == CMD_LOAD);

	kmg_cfg u_cfg (.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .cfg);

	kmg_ram #(.WIDTH(DIST_WIDTH), .DEPTH(MAX_CLIENTS*MAX_FACILITIES)) u_ram (
		.clk, .we, .waddr({r.client_index, r.facility_index}),
		.wdata(r.distance[DIST_WIDTH-1:0]), .raddr, .rdata);

	kmg_seq u_seq (.clk, .arst_n, .cfg, .start(acc && r.cmd == CMD_START), .busy,
		.raddr, .rdata, .res_valid(res.valid), .res_ready(res.ready), .res(res.data));
endmodule

@@ rtl/core/kmg_ram.sv @@
module kmg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/core/kmg_cfg.sv @@
module kmg_cfg (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [kmg_pkg::PAW-1:0] paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	output kmg_pkg::kmg_cfg_t       cfg
);
	import kmg_pkg::*;

	logic [6:0] nc_q, nf_q, k_q;
	logic wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nc_q <= 7'd1;
			nf_q <= 7'd1;
			k_q  <= 7'd1;
		end else if (wr) begin
			if (paddr == REG_CLIENTS)    nc_q <= pwdata[6:0];
			if (paddr == REG_FACILITIES) nf_q <= pwdata[6:0];
			if (paddr == REG_LIMIT)      k_q  <= pwdata[6:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == REG_CLIENTS)         prdata[6:0] = nc_q;
		else if (paddr == REG_FACILITIES) prdata[6:0] = nf_q;
		else if (paddr == REG_LIMIT)      prdata[6:0] = k_q;
	end

	assign cfg.nc = clamp_cnt(nc_q, MAX_CLIENTS);
	assign cfg.nf = clamp_cnt(nf_q, MAX_FACILITIES);
	assign cfg.k  = clamp_cnt(k_q, MAX_FACILITIES);
endmodule

@@ rtl/core/kmg_seq.sv @@
// Sequencer: one matrix entry per cycle through a shared min/add/compare datapath.
module kmg_seq (
	input  logic                    clk,
	input  logic                    arst_n,
	input  kmg_pkg::kmg_cfg_t       cfg,
	input  logic                    start,
	output logic                    busy,
	output logic [kmg_pkg::AW-1:0]  raddr,
	input  logic [kmg_pkg::DIST_WIDTH-1:0] rdata,
	output logic                    res_valid,
	input  logic                    res_ready,
	output kmg_pkg::kmg_res_t       res
);
	import kmg_pkg::*;

	kmg_state_t state_q, state_d;
	logic [6:0] ci_q, fj_q;          // walk counters (hold count value)
	logic [CW-1:0] rd_ci_s1;         // client of entry in flight
	logic rd_v_s1;
	logic [COSTW-1:0] sum_q, best_cost_q, cur_cost_q;
	logic [FW-1:0] best_j_q;
	logic found_q;
	logic [6:0] round_q, opened_q;
	logic [MAX_FACILITIES-1:0] open_q;
	logic [TOTW-1:0] total_q;
	logic [BDW-1:0] abd_q;
	logic [FW-1:0] abf_q, rd_f_s1;

	logic [BDW-1:0] d_ext, cur_bd, mn, bd_rdata, bd_wdata, asg_b;
	logic [FW-1:0] bf_rdata, asg_f;
	logic [CW-1:0] bd_raddr, bd_waddr;
	logic bd_we, bf_we;
	logic lt, last_c, last_f;
	logic [6:0] ci_nx;

	assign d_ext  = {1'b0, rdata};
	// nothing is open before the first update: every client is still unreached
	assign cur_bd = (round_q == '0) ? '1 : bd_rdata;
	// shared compare unit
	assign lt = (state_q == ST_ASSIGN || state_q == ST_ASSIGN_DRAIN) ?
		(d_ext < abd_q) : (d_ext < cur_bd);
	assign mn = lt ? d_ext : cur_bd;

	assign ci_nx  = ci_q + 7'd1;
	assign last_c = (ci_nx == cfg.nc);
	assign last_f = (fj_q + 7'd1 == cfg.nf);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (start) state_d = ST_INIT;
			ST_INIT:  state_d = ST_EVAL;
			ST_EVAL:  if (open_q[fj_q[FW-1:0]] || last_c) state_d = ST_DRAIN;
			ST_DRAIN: state_d = last_f ? ST_PICK : ST_EVAL;
			ST_PICK:  state_d = (found_q) ? ST_UPD : ST_ASSIGN;
			ST_UPD:   if (last_c) state_d = ST_UPD_DRAIN;
			ST_UPD_DRAIN: state_d = (round_q + 7'd1 == cfg.k || opened_q == cfg.nf)
				? ST_ASSIGN : ST_EVAL;
			ST_ASSIGN: if (last_f) state_d = ST_ASSIGN_DRAIN;
			ST_ASSIGN_DRAIN: state_d = last_c ? ST_FETCH : ST_ASSIGN;
			ST_FETCH: state_d = ST_EMIT;
			ST_EMIT:  if (res_ready && last_c) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		raddr = {ci_q[CW-1:0], fj_q[FW-1:0]};
	end

	// per-client store: read ahead so the row on the output matches ci_q
	always_comb begin
		bd_raddr = ci_q[CW-1:0];
		if (state_q == ST_EMIT && res_ready) bd_raddr = ci_nx[CW-1:0];
	end

	always_comb begin
		asg_b = abd_q;
		asg_f = abf_q;
		if (rd_v_s1 && lt) begin
			asg_b = d_ext;
			asg_f = rd_f_s1;
		end
		if (asg_b == '1) asg_b = '0;
		bd_we = 1'b0;
		bd_waddr = rd_ci_s1;
		bd_wdata = mn;
		bf_we = 1'b0;
		if ((state_q == ST_UPD && rd_v_s1) || state_q == ST_UPD_DRAIN) bd_we = 1'b1;
		if (state_q == ST_ASSIGN_DRAIN) begin
			bd_we = 1'b1;
			bd_waddr = ci_q[CW-1:0];
			bd_wdata = asg_b;
			bf_we = 1'b1;
		end
	end

	kmg_ram #(.WIDTH(BDW), .DEPTH(MAX_CLIENTS)) u_bd (
		.clk, .we(bd_we), .waddr(bd_waddr), .wdata(bd_wdata),
		.raddr(bd_raddr), .rdata(bd_rdata));

	kmg_ram #(.WIDTH(FW), .DEPTH(MAX_CLIENTS)) u_bf (
		.clk, .we(bf_we), .waddr(ci_q[CW-1:0]), .wdata(asg_f),
		.raddr(bd_raddr), .rdata(bf_rdata));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ci_q <= '0; fj_q <= '0; rd_v_s1 <= 1'b0; round_q <= '0; opened_q <= '0;
			open_q <= '0; found_q <= 1'b0;
			rd_ci_s1 <= '0; rd_f_s1 <= '0; best_j_q <= '0;
			sum_q <= '0; best_cost_q <= '1; cur_cost_q <= '1;
			total_q <= '0; abd_q <= '1; abf_q <= '0;
		end else begin
			rd_v_s1 <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					ci_q <= '0; fj_q <= '0;
				end
				ST_INIT: begin
					open_q <= '0; round_q <= '0; opened_q <= '0; found_q <= 1'b0;
					cur_cost_q <= '1; best_cost_q <= '1; sum_q <= '0;
				end
				ST_EVAL: begin
					// skip open facility: no reads
					if (!open_q[fj_q[FW-1:0]]) begin
						rd_v_s1 <= 1'b1;
						rd_ci_s1 <= ci_q[CW-1:0];
						ci_q <= last_c ? '0 : ci_nx;
					end
					if (rd_v_s1) sum_q <= sum_q + COSTW'(mn);
				end
				ST_DRAIN: begin
					logic [COSTW-1:0] s;
					s = rd_v_s1 ? sum_q + COSTW'(mn) : sum_q;
					if (!open_q[fj_q[FW-1:0]] && s < best_cost_q) begin
						best_cost_q <= s; best_j_q <= fj_q[FW-1:0]; found_q <= 1'b1;
					end
					sum_q <= '0; ci_q <= '0;
					fj_q <= last_f ? '0 : fj_q + 7'd1;
				end
				ST_PICK: begin
					if (found_q) begin
						open_q[best_j_q] <= 1'b1;
						opened_q <= opened_q + 7'd1;
						cur_cost_q <= best_cost_q;
						fj_q <= 7'(best_j_q);
					end
					ci_q <= '0;
				end
				ST_UPD: begin
					rd_v_s1 <= 1'b1;
					rd_ci_s1 <= ci_q[CW-1:0];
					ci_q <= last_c ? '0 : ci_nx;
				end
				ST_UPD_DRAIN: begin
					round_q <= round_q + 7'd1;
					found_q <= 1'b0;
					best_cost_q <= cur_cost_q;
					fj_q <= '0; ci_q <= '0;
					abd_q <= '1; total_q <= '0;
				end
				ST_ASSIGN: begin
					rd_v_s1 <= open_q[fj_q[FW-1:0]];
					rd_f_s1 <= fj_q[FW-1:0];
					fj_q <= last_f ? '0 : fj_q + 7'd1;
					if (rd_v_s1 && lt) begin abd_q <= d_ext; abf_q <= rd_f_s1; end
					if (fj_q == '0) begin abd_q <= '1; abf_q <= '0; end
				end
				ST_ASSIGN_DRAIN: begin
					total_q <= total_q + TOTW'(asg_b);
					abd_q <= '1; abf_q <= '0;
					ci_q <= last_c ? '0 : ci_nx;
				end
				ST_EMIT: begin
					if (res_ready) ci_q <= ci_nx;
				end
				default: ;
			endcase
			if (state_q == ST_PICK && !found_q) begin
				fj_q <= '0; abd_q <= '1; abf_q <= '0; total_q <= '0;
			end
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign res_valid = (state_q == ST_EMIT);
	assign res.client_id = ci_q[CW-1:0];
	assign res.assigned_facility = bf_rdata;
	assign res.client_distance = bd_rdata[DIST_WIDTH-1:0];
	assign res.cost_sum = total_q;
	assign res.opened_count = opened_q;
	assign res.last = last_c;

	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> busy) else $error("emit while idle");
	a_opened_le_k: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (opened_q <= cfg.k && opened_q != '0))
		else $error("opened count out of range");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready && res.last) |=> state_q == ST_IDLE)
		else $error("no idle after last row");
endmodule
